// File: rtl/dss_pkg.sv
// Shared types and constants for the dual stack over one shared array.
// Used by dss_front, dss_back and dual_stack_shared_array. No dependencies.
package dss_pkg;

  // Default number of words in the shared store
  localparam int unsigned DssDepth = 32;

  // Entries in the queue between front and back
  localparam int unsigned QueueDepth = 2;

  // Input kind codes
  typedef enum logic [2:0] {
    KIND_PUSH_ONE = 3'd0,
    KIND_POP_ONE  = 3'd1,
    KIND_LIST_ONE = 3'd2,
    KIND_PUSH_TWO = 3'd3,
    KIND_POP_TWO  = 3'd4,
    KIND_LIST_TWO = 3'd5
  } kind_e;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_OVERFLOW  = 2'd1,
    STATUS_UNDERFLOW = 2'd2,
    STATUS_EMPTY     = 2'd3
  } status_e;

  // Decoded operation
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_LIST = 2'd2
  } op_e;

  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  // Classified command handed from front to back
  typedef struct packed {
    op_e                op;
    logic               sel_two;
    logic signed [31:0] value;
  } cmd_t;

endpackage

// File: rtl/dual_stack_shared_array.sv
// Top level: two stacks growing toward each other in one shared store.
// Depends on dss_pkg, dss_front and dss_back.
//
//   channel | direction | payload             | handshake
//   --------+-----------+---------------------+------------------------
//   in      | input     | in_item_i (kind,    | in_valid_i / in_stall_o
//           |           |   value)            |
//   out     | output    | out_item_o (data,   | out_valid_o / out_stall_i
//           |           |   status, last)     |
//
// Push and pop each yield one result item in the back end; a list yields one item
// per stored entry (one for an empty stack), read through the single read port.
// A result is registered at the edge its command issues from the head of the two-entry
// queue; a list issues once per entry and leaves the queue with its final entry.
// Reset clears both counts and the queue; store contents stay undefined.
// An output stall halts the back end; the queue then fills and stalls input.
module dual_stack_shared_array #(
  parameter int unsigned DEPTH = dss_pkg::DssDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dss_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output dss_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_deq;
  dss_pkg::cmd_t cmd;

  // Accept and classify
  dss_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_deq_i   (cmd_deq)
  );

  // Execute against the store
  dss_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_deq_o   (cmd_deq),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

// File: rtl/dss_front.sv
// Front end: accepts input items, classifies them and queues commands.
// Depends on dss_pkg.
module dss_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  dss_pkg::in_item_t in_item_i,
  output logic             cmd_valid_o,
  output dss_pkg::cmd_t    cmd_o,
  input  logic             cmd_deq_i
);

  localparam int unsigned PW = (dss_pkg::QueueDepth > 1) ? $clog2(dss_pkg::QueueDepth) : 1;
  localparam int unsigned NW = $clog2(dss_pkg::QueueDepth + 1);

  dss_pkg::cmd_t    queue_q [dss_pkg::QueueDepth];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    fill_q, fill_d;
  logic             full;
  logic             known;
  logic             enq;
  logic             deq;
  dss_pkg::cmd_t    cmd_new;

  // Classify the incoming kind; unused codes are accepted and dropped
  always_comb begin
    known           = 1'b1;
    cmd_new.value   = in_item_i.value;
    cmd_new.op      = dss_pkg::OP_PUSH;
    cmd_new.sel_two = 1'b0;
    unique case (dss_pkg::kind_e'(in_item_i.kind))
      dss_pkg::KIND_PUSH_ONE: cmd_new.op = dss_pkg::OP_PUSH;
      dss_pkg::KIND_POP_ONE:  cmd_new.op = dss_pkg::OP_POP;
      dss_pkg::KIND_LIST_ONE: cmd_new.op = dss_pkg::OP_LIST;
      dss_pkg::KIND_PUSH_TWO: begin
        cmd_new.op      = dss_pkg::OP_PUSH;
        cmd_new.sel_two = 1'b1;
      end
      dss_pkg::KIND_POP_TWO: begin
        cmd_new.op      = dss_pkg::OP_POP;
        cmd_new.sel_two = 1'b1;
      end
      dss_pkg::KIND_LIST_TWO: begin
        cmd_new.op      = dss_pkg::OP_LIST;
        cmd_new.sel_two = 1'b1;
      end
      default: known = 1'b0;
    endcase
  end

  // Queue bookkeeping
  assign full        = (fill_q == NW'(dss_pkg::QueueDepth));
  assign in_stall_o  = full;
  assign enq         = in_valid_i && !full && known;
  assign cmd_valid_o = (fill_q != '0);
  assign deq         = cmd_deq_i && cmd_valid_o;
  assign cmd_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    if (enq) begin
      wr_ptr_d = (wr_ptr_q == PW'(dss_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (deq) begin
      rd_ptr_d = (rd_ptr_q == PW'(dss_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (enq && !deq) begin
      fill_d = fill_q + 1'b1;
    end else if (deq && !enq) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Queue payload, no reset
  always_ff @(posedge clk_i) begin
    if (enq) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

// File: rtl/dss_back.sv
// Back end: executes push, pop and list against the shared store and
// drives the output register. Depends on dss_pkg.
module dss_back #(
  parameter int unsigned DEPTH = dss_pkg::DssDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  dss_pkg::cmd_t     cmd_i,
  output logic              cmd_deq_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dss_pkg::out_item_t out_item_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  // Shared store
  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata_q;

  // Stack counts and list walk index
  logic [CW-1:0] low_q, low_d;
  logic [CW-1:0] high_q, high_d;
  logic [AW-1:0] idx_q, idx_d;

  // Output stage
  logic              b_valid_q;
  dss_pkg::status_e  b_status_q;
  logic              b_last_q;
  logic              b_mem_q;

  logic              issue;
  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [CW-1:0]     cnt;
  logic [CW:0]       total;
  dss_pkg::status_e  st;
  logic              last;
  logic              use_mem;

  assign cnt   = cmd_i.sel_two ? high_q : low_q;
  assign total = {1'b0, low_q} + {1'b0, high_q};
  assign issue = cmd_valid_i && (!b_valid_q || !out_stall_i);

  // Execute the command at the head of the queue
  always_comb begin
    low_d     = low_q;
    high_d    = high_q;
    idx_d     = idx_q;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    wr_addr   = '0;
    rd_addr   = '0;
    st        = dss_pkg::STATUS_OK;
    last      = 1'b1;
    use_mem   = 1'b0;
    cmd_deq_o = 1'b0;
    if (issue) begin
      cmd_deq_o = 1'b1;
      unique case (cmd_i.op)
        dss_pkg::OP_PUSH: begin
          if (total >= (CW+1)'(DEPTH)) begin
            st = dss_pkg::STATUS_OVERFLOW;
          end else begin
            wr_en = 1'b1;
            if (cmd_i.sel_two) begin
              wr_addr = AW'(CW'(DEPTH - 1) - high_q);
              high_d  = high_q + 1'b1;
            end else begin
              wr_addr = AW'(low_q);
              low_d   = low_q + 1'b1;
            end
          end
        end
        dss_pkg::OP_POP: begin
          if (cnt == '0) begin
            st = dss_pkg::STATUS_UNDERFLOW;
          end else begin
            rd_en   = 1'b1;
            use_mem = 1'b1;
            if (cmd_i.sel_two) begin
              rd_addr = AW'(CW'(DEPTH) - high_q);
              high_d  = high_q - 1'b1;
            end else begin
              rd_addr = AW'(low_q - 1'b1);
              low_d   = low_q - 1'b1;
            end
          end
        end
        dss_pkg::OP_LIST: begin
          if (cnt == '0) begin
            st = dss_pkg::STATUS_EMPTY;
          end else begin
            rd_en   = 1'b1;
            use_mem = 1'b1;
            rd_addr = cmd_i.sel_two ? AW'(DEPTH - 1) - idx_q : idx_q;
            last    = ({1'b0, idx_q} + 1'b1) == (AW+1)'(cnt);
            // Hold the command until the final entry goes out
            cmd_deq_o = last;
            idx_d     = last ? '0 : idx_q + 1'b1;
          end
        end
        default: st = dss_pkg::STATUS_OK;
      endcase
    end
  end

  // Store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd_i.value;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  // Control state and output stage flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      low_q      <= '0;
      high_q     <= '0;
      idx_q      <= '0;
      b_valid_q  <= 1'b0;
      b_status_q <= dss_pkg::STATUS_OK;
      b_last_q   <= 1'b0;
      b_mem_q    <= 1'b0;
    end else begin
      low_q  <= low_d;
      high_q <= high_d;
      idx_q  <= idx_d;
      if (issue) begin
        b_valid_q  <= 1'b1;
        b_status_q <= st;
        b_last_q   <= last;
        b_mem_q    <= use_mem;
      end else if (!out_stall_i) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o       = b_valid_q;
  assign out_item_o.data   = b_mem_q ? rdata_q : '0;
  assign out_item_o.status = b_status_q;
  assign out_item_o.last   = b_last_q;

endmodule

// File: tb/sv/dual_stack_shared_array_test.sv
// Self-checking testbench for dual_stack_shared_array: two stacks in one shared store.
// Depends on dss_pkg and the dual_stack_shared_array RTL; predicts results from its own
// copy of both stacks and checks every result item against that prediction.
module dual_stack_shared_array_test;

  localparam int unsigned Depth       = dss_pkg::DssDepth;
  localparam int unsigned ClkPeriod   = 4;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned MaxWait     = 13;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit  = 500000;
  localparam int unsigned RandomOps   = 70;

  // Kind codes the block must ignore
  localparam logic [2:0] KindUnusedLo = 3'd6;
  localparam logic [2:0] KindUnusedHi = 3'd7;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  dss_pkg::in_item_t  in_item   = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  dss_pkg::out_item_t out_item;

  // Predicted state: shared store and the depth of each stack
  logic signed [31:0] stack_mem [Depth];
  int unsigned        up_cnt;
  int unsigned        down_cnt;
  dss_pkg::out_item_t pending_results [$];

  // When set, that side never idles
  bit in_quiet;
  bit out_quiet;

  int unsigned errors;
  int unsigned results_checked;
  int unsigned n_push, n_pop, n_list, n_ignored, n_overflow, n_underflow;
  int unsigned cycle_cnt;

  dual_stack_shared_array #(
    .DEPTH(Depth)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always #(ClkPeriod / 2) clk = ~clk;

  function automatic int unsigned draw_wait(input bit quiet);
    return quiet ? 0 : $urandom_range(0, MaxWait);
  endfunction

  // Mostly random words, with the signed extremes mixed in
  function automatic logic signed [31:0] random_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Apply one command to the predicted stacks and queue the results it causes
  function automatic void predict_stack_op(input dss_pkg::in_item_t it);
    dss_pkg::out_item_t r;
    dss_pkg::op_e       op;
    bit                 two;
    int unsigned        depth_of;
    int unsigned        j;
    case (it.kind)
      dss_pkg::KIND_PUSH_ONE, dss_pkg::KIND_PUSH_TWO: op = dss_pkg::OP_PUSH;
      dss_pkg::KIND_POP_ONE, dss_pkg::KIND_POP_TWO:   op = dss_pkg::OP_POP;
      dss_pkg::KIND_LIST_ONE, dss_pkg::KIND_LIST_TWO: op = dss_pkg::OP_LIST;
      default: begin
        n_ignored++;
        return;
      end
    endcase
    two      = (it.kind >= dss_pkg::KIND_PUSH_TWO);
    depth_of = two ? down_cnt : up_cnt;
    r        = '0;
    r.status = dss_pkg::STATUS_OK;
    r.last   = 1'b1;
    case (op)
      dss_pkg::OP_PUSH: begin
        n_push++;
        // full when the two stacks together fill the store
        if (up_cnt + down_cnt >= Depth) begin
          r.status = dss_pkg::STATUS_OVERFLOW;
          n_overflow++;
        end else if (two) begin
          down_cnt++;
          stack_mem[Depth - down_cnt] = it.value;
        end else begin
          stack_mem[up_cnt] = it.value;
          up_cnt++;
        end
        pending_results.push_back(r);
      end
      dss_pkg::OP_POP: begin
        n_pop++;
        if (depth_of == 0) begin
          r.status = dss_pkg::STATUS_UNDERFLOW;
          n_underflow++;
        end else if (two) begin
          r.data = stack_mem[Depth - down_cnt];
          down_cnt--;
        end else begin
          up_cnt--;
          r.data = stack_mem[up_cnt];
        end
        pending_results.push_back(r);
      end
      default: begin
        n_list++;
        if (depth_of == 0) begin
          r.status = dss_pkg::STATUS_EMPTY;
          pending_results.push_back(r);
        end else begin
          // bottom to top, last flag on the top entry only
          for (j = 0; j < depth_of; j++) begin
            r.data = stack_mem[two ? Depth - 1 - j : j];
            r.last = (j + 1 == depth_of);
            pending_results.push_back(r);
          end
        end
      end
    endcase
  endfunction

  // Send one item after a random gap; valid stays high if the next gap is zero
  task automatic send_stack_cmd(input logic [2:0] cmd_kind, input logic signed [31:0] word);
    int unsigned gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= '{kind: cmd_kind, value: word};
    do @(posedge clk); while (in_stall);
    predict_stack_op(in_item);
  endtask

  // Output stall: random hold-off before each result item
  initial begin
    int unsigned hold;
    forever begin
      hold = draw_wait(out_quiet);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    dss_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: expected none, got data=%0d status=%0d last=%0b",
                 $time, out_item.data, out_item.status, out_item.last);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_item.data !== want.data) begin
          errors++;
          $display("%0t: data mismatch: expected %0d, got %0d",
                   $time, want.data, out_item.data);
        end
        if (out_item.status !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, got %0d",
                   $time, want.status, out_item.status);
        end
        if (out_item.last !== want.last) begin
          errors++;
          $display("%0t: last mismatch: expected %0b, got %0b",
                   $time, want.last, out_item.last);
        end
      end
    end
  end

  // Edge cases on empty stacks, word extremes, ignored kinds
  task automatic test_basic_ops();
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_POP_TWO, '0);
    send_stack_cmd(dss_pkg::KIND_LIST_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_LIST_TWO, '0);
    send_stack_cmd(KindUnusedLo, 32'h1234_5678);
    send_stack_cmd(KindUnusedHi, 32'hFFFF_FFFF);
    send_stack_cmd(dss_pkg::KIND_PUSH_ONE, 32'h8000_0000);
    send_stack_cmd(dss_pkg::KIND_PUSH_ONE, 32'h7FFF_FFFF);
    send_stack_cmd(dss_pkg::KIND_PUSH_TWO, 32'h0000_0000);
    send_stack_cmd(dss_pkg::KIND_PUSH_TWO, 32'hFFFF_FFFF);
    send_stack_cmd(dss_pkg::KIND_PUSH_ONE, 32'h5A5A_A5A5);
    send_stack_cmd(dss_pkg::KIND_LIST_ONE, 32'hFFFF_FFFF);
    send_stack_cmd(dss_pkg::KIND_LIST_TWO, '0);
    send_stack_cmd(dss_pkg::KIND_POP_TWO, 32'hFFFF_FFFF);
    send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_POP_TWO, '0);
    send_stack_cmd(dss_pkg::KIND_POP_TWO, '0);
    send_stack_cmd(dss_pkg::KIND_LIST_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_LIST_TWO, '0);
  endtask

  // Fill the store, bounce off the full mark, list long stacks, drain to empty
  task automatic test_fill_and_drain();
    int unsigned step;
    in_quiet  = 1'b1;
    out_quiet = 1'b0;
    while (up_cnt + down_cnt < Depth)
      send_stack_cmd(($urandom_range(0, 3) != 0) ? dss_pkg::KIND_PUSH_ONE
                                                 : dss_pkg::KIND_PUSH_TWO,
                     random_word());
    send_stack_cmd(dss_pkg::KIND_PUSH_ONE, random_word());
    send_stack_cmd(dss_pkg::KIND_PUSH_TWO, random_word());
    send_stack_cmd(dss_pkg::KIND_LIST_ONE, '0);
    send_stack_cmd(dss_pkg::KIND_LIST_TWO, '0);

    // free one slot, take it with a push on the second stack, then overflow again
    in_quiet  = 1'b0;
    out_quiet = 1'b1;
    send_stack_cmd((up_cnt > 0) ? dss_pkg::KIND_POP_ONE : dss_pkg::KIND_POP_TWO, '0);
    send_stack_cmd(dss_pkg::KIND_PUSH_TWO, random_word());
    send_stack_cmd(dss_pkg::KIND_PUSH_ONE, random_word());

    out_quiet = 1'b0;
    step = 0;
    while (up_cnt + down_cnt > 0) begin
      if (step % 8 == 7)
        send_stack_cmd($urandom_range(0, 1) ? dss_pkg::KIND_LIST_ONE
                                            : dss_pkg::KIND_LIST_TWO, '0);
      else if (up_cnt == 0)
        send_stack_cmd(dss_pkg::KIND_POP_TWO, '0);
      else if (down_cnt == 0)
        send_stack_cmd(dss_pkg::KIND_POP_ONE, '0);
      else
        send_stack_cmd($urandom_range(0, 1) ? dss_pkg::KIND_POP_ONE
                                            : dss_pkg::KIND_POP_TWO, '0);
      step++;
    end
    send_stack_cmd(dss_pkg::KIND_POP_ONE, random_word());
    send_stack_cmd(dss_pkg::KIND_POP_TWO, random_word());
  endtask

  // Random mix of all kinds; phases alternate push-heavy and pop-heavy
  task automatic test_random_mix();
    int unsigned issued;
    int unsigned pick;
    int unsigned push_pct;
    logic [2:0]  k;
    issued   = 0;
    push_pct = 60;
    while (issued < RandomOps) begin
      if (issued % 16 == 0) begin
        in_quiet  = ($urandom_range(0, 2) == 0);
        out_quiet = ($urandom_range(0, 2) == 0);
        push_pct  = (push_pct == 60) ? 35 : 60;
      end
      pick = $urandom_range(0, 99);
      if (pick < 4)
        k = $urandom_range(0, 1) ? KindUnusedLo : KindUnusedHi;
      else if (pick < 4 + push_pct)
        k = $urandom_range(0, 1) ? dss_pkg::KIND_PUSH_ONE : dss_pkg::KIND_PUSH_TWO;
      else if (pick < 86)
        k = $urandom_range(0, 1) ? dss_pkg::KIND_POP_ONE : dss_pkg::KIND_POP_TWO;
      else
        k = $urandom_range(0, 1) ? dss_pkg::KIND_LIST_ONE : dss_pkg::KIND_LIST_TWO;
      send_stack_cmd(k, random_word());
      if (k <= dss_pkg::KIND_LIST_TWO)
        issued++;
    end
  endtask

  // Run limit
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("%0t: run limit of %0d cycles reached, %0d results outstanding",
             $time, CycleLimit, pending_results.size());
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    in_quiet  = 1'b0;
    out_quiet = 1'b0;
    repeat (ResetCycles) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_ops();
    test_fill_and_drain();
    test_random_mix();

    // let the last results come out, then watch for strays
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display({"Covered %0d pushes (%0d refused when full), %0d pops (%0d on empty), ",
              "%0d lists, %0d ignored kinds."},
             n_push, n_overflow, n_pop, n_underflow, n_list, n_ignored);
    $display("Checked %0d result items against the predicted stacks; %0d mismatches.",
             results_checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/dss_pkg.sv
rtl/dss_front.sv
rtl/dss_back.sv
rtl/dual_stack_shared_array.sv
tb/sv/dual_stack_shared_array_test.sv
